### rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

	// Default sizes of the ring buffer.
	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	// Fixed widths of the request and response fields.
	localparam int REQ_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request kinds.
	localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PEEK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;	// capture the request word
		logic exec;	// access the buffer and update the pointers
	} dq_cmd_t;

endpackage

### rtl/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output dq_pkg::dq_cmd_t cmd
);
	import dq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic       accept;

	// A request is taken whenever no access is in progress, also while a response shows.
	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;
	assign done   = (state_q == S_RESP);

	assign cmd.load = accept;
	assign cmd.exec = (state_q == S_EXEC);

	// Sequence: capture, buffer access, response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					state_q <= accept ? S_EXEC : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/dq_datapath.sv
`timescale 1ns / 1ps

module dq_datapath #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF,
	parameter int WIDTH = dq_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dq_pkg::dq_cmd_t               cmd,
	input  logic [dq_pkg::REQ_W-1:0]      req_type,
	input  logic                          at_front,
	input  logic [dq_pkg::VALUE_W-1:0]    item_value,
	output logic [dq_pkg::STATUS_W-1:0]   status,
	output logic [dq_pkg::VALUE_W-1:0]    read_value,
	output logic [dq_pkg::COUNT_W-1:0]    entry_count
);
	import dq_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// Captured request.
	logic [REQ_W-1:0]   req_q;
	logic               front_q;
	logic [WIDTH-1:0]   word_q;

	// Ring pointers and fill level.
	logic [IW-1:0]      head_q;
	logic [IW-1:0]      tail_q;
	logic [CW-1:0]      count_q;

	// Response registers.
	logic [STATUS_W-1:0] status_q;
	logic                rd_ok_q;
	logic [WIDTH-1:0]    rd_q;

	logic [WIDTH-1:0]    slot_mem [DEPTH];

	logic [WIDTH+VALUE_W-1:0] wr_ext;
	logic [WIDTH+VALUE_W-1:0] rd_ext;
	logic [CW+COUNT_W-1:0]    cnt_ext;

	logic [IW-1:0] head_prev, head_next, tail_prev, tail_next;
	logic          is_full, is_empty;
	logic          do_push, do_read, do_pop;
	logic [IW-1:0] wr_idx, rd_idx;

	// The stored word keeps the low WIDTH bits of the pushed value.
	assign wr_ext = {{WIDTH{1'b0}}, item_value};

	// Capture the request when it is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			front_q <= at_front;
			word_q  <= wr_ext[WIDTH-1:0];
		end
	end

	// Neighbouring slots around the ring.
	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);

	// Decode of the access for this request.
	assign do_push = cmd.exec && (req_q == REQ_PUSH) && !is_full;
	assign do_read = cmd.exec && ((req_q == REQ_PEEK) || (req_q == REQ_POP)) && !is_empty;
	assign do_pop  = do_read && (req_q == REQ_POP);
	assign wr_idx  = front_q ? head_prev : tail_q;
	assign rd_idx  = front_q ? head_q : tail_prev;

	// Buffer storage with a registered read port.
	always_ff @(posedge clk) begin
		if (do_push) slot_mem[wr_idx] <= word_q;
		if (do_read) rd_q <= slot_mem[rd_idx];
	end

	// Pointer, count and status update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			status_q <= ST_OK;
			rd_ok_q  <= 1'b0;
		end else if (cmd.exec) begin
			rd_ok_q  <= do_read;
			case (req_q)
				REQ_PUSH: begin
					if (is_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
						if (front_q) head_q <= head_prev;
						else         tail_q <= tail_next;
						count_q <= count_q + 1'b1;
					end
				end
				REQ_PEEK: begin
					status_q <= is_empty ? ST_EMPTY : ST_OK;
				end
				REQ_POP: begin
					if (is_empty) begin
						status_q <= ST_EMPTY;
					end else begin
						status_q <= ST_OK;
						if (front_q) head_q <= head_next;
						else         tail_q <= tail_prev;
						count_q <= count_q - 1'b1;
					end
				end
				REQ_CLEAR: begin
					status_q <= ST_OK;
					head_q   <= '0;
					tail_q   <= '0;
					count_q  <= '0;
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	// Response word: read data only for a successful peek or pop.
	assign rd_ext      = {{VALUE_W{1'b0}}, rd_q};
	assign cnt_ext     = {{COUNT_W{1'b0}}, count_q};
	assign status      = status_q;
	assign read_value  = rd_ok_q ? rd_ext[VALUE_W-1:0] : '0;
	assign entry_count = cnt_ext[COUNT_W-1:0];

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue held in a ring buffer of DEPTH words.
// Request channel: a word is taken at a rising edge where start is high and
// busy is low; req_type selects push, peek, pop or clear and at_front picks
// the end acted on. item_value is stored by a push, low WIDTH bits kept.
// Response channel: done is high for exactly one cycle per request, with
// status (ok, full or empty), read_value (0 unless a peek or pop succeeds)
// and entry_count, the number of entries held after the request.
// Each request is captured at acceptance, then the buffer is accessed with
// its registered read port, and the response shows in the state after that.
// No new request is taken while an access runs; busy is high only during the
// access cycle, so a new request may be given while a response shows.
// The receiver cannot stall; a response is gone after its cycle.
// Reset empties the queue and clears both pointers; the buffer contents are
// not cleared, and only slots holding entries are ever read.
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF,
	parameter int WIDTH = dq_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [dq_pkg::REQ_W-1:0]      req_type,
	input  logic                          at_front,
	input  logic [dq_pkg::VALUE_W-1:0]    item_value,
	output logic                          done,
	output logic [dq_pkg::STATUS_W-1:0]   status,
	output logic [dq_pkg::VALUE_W-1:0]    read_value,
	output logic [dq_pkg::COUNT_W-1:0]    entry_count
);
	import dq_pkg::*;

	dq_cmd_t cmd;

	// Sequencing of each request.
	dq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Buffer, pointers and response registers.
	dq_datapath #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req_type),
		.at_front    (at_front),
		.item_value  (item_value),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

endmodule
